// ----- hw/rtl/multi_axis_bresenham_step_generator_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the step generator
// Shared concurrent assertion forms, clocked on clk with async low reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_AXIS_BRESENHAM_STEP_GENERATOR_TOP_MACROS_SVH
`define MULTI_AXIS_BRESENHAM_STEP_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication
`define MABSG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MABSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mabsg_pkg.sv -----
// ----------------------------------------------------------------------------
// mabsg_pkg
// Shared types and constants for the multi-axis Bresenham step generator.
// ----------------------------------------------------------------------------
package mabsg_pkg;

    // Default number of axis slots
    localparam int AXES_DEFAULT = 8;

    // Fixed pin vector width (one bit per axis)
    localparam int PIN_W = 8;

    // Input word function codes
    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STEP  = 2'd2,
        FUNC_PULSE = 2'd3
    } func_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_TARGET_MODE = 2'd0,
        REG_ACTIVE_AXES = 2'd1
    } cfg_reg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // input word taken this cycle
        logic rd_en;    // read axis stores at rd_addr
        logic walk_en;  // update follower axis at walk_axis
        logic capture;  // load the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic       running;
        logic       lead_pin;
        logic [3:0] axis_count;
    } status_t;

endpackage

// ----- hw/rtl/multi_axis_bresenham_step_generator_top.sv -----
// ----------------------------------------------------------------------------
// multi_axis_bresenham_step_generator_top
// Multi-axis step pulse generator with Bresenham distribution.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word: load axis, start move,
//   step tick or pulse-end tick. Every word returns exactly one result word
//   on the output channel (out_valid/out_ready): pin levels, lead position,
//   running and target_reached.
//   Config channel (cfg_valid/cfg_ready, always ready) writes target_mode
//   (index 0) and active_axes (index 1); write only when idle.
// Timing:
//   Load, start, pulse-end and ignored step ticks go from accept straight
//   to the finish state. A live step tick first walks the follower axes,
//   one per cycle through the shared error and position update unit on
//   the single store read port.
//   A new word is taken while the previous result still sits unclaimed;
//   if the receiver stalls, the finished word waits and input stalls then.
// Reset:
//   Pins, directions, lead target and run state clear; target_mode = 1,
//   active_axes = 1. Axis stores hold nothing valid until loaded.
// ----------------------------------------------------------------------------
`include "multi_axis_bresenham_step_generator_top_macros.svh"

module multi_axis_bresenham_step_generator_top
    import mabsg_pkg::*;
#(
    parameter int AXES = AXES_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [3:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          func,
    input  logic [2:0]          axis,
    input  logic [30:0]         axis_rate,
    input  logic signed [31:0]  error_init,
    input  logic                direction,
    input  logic signed [31:0]  position_init,
    input  logic signed [31:0]  target_position,
    input  logic                reverse_request,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PIN_W-1:0]    step_pins,
    output logic [PIN_W-1:0]    dir_pins,
    output logic signed [31:0]  lead_position,
    output logic                running,
    output logic                target_reached
);

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

    cmd_t          cmd;
    status_t       status;
    logic [AW-1:0] walk_axis;
    logic [AW-1:0] rd_addr;

    assign cfg_ready = 1'b1;

    // Sequencer
    mabsg_ctrl #(
        .AXES (AXES),
        .AW   (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .walk_axis (walk_axis),
        .rd_addr   (rd_addr)
    );

    // Axis datapath
    mabsg_datapath #(
        .AXES (AXES),
        .AW   (AW)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .walk_axis       (walk_axis),
        .rd_addr         (rd_addr),
        .status          (status),
        .cfg_we          (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .func            (func),
        .axis            (axis),
        .axis_rate       (axis_rate),
        .error_init      (error_init),
        .direction       (direction),
        .position_init   (position_init),
        .target_position (target_position),
        .reverse_request (reverse_request),
        .step_pins       (step_pins),
        .dir_pins        (dir_pins),
        .lead_position   (lead_position),
        .running         (running),
        .target_reached  (target_reached)
    );

    // One word in flight at a time
    `MABSG_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "word accepted while busy")
    // A reached report always ends the move
    `MABSG_ASSERT_SAME(a_reached_stops, clk, rst_n, out_valid && target_reached, !running, "reached while running")
    // Followers never step without the lead axis
    `MABSG_ASSERT_SAME(a_lead_steps, clk, rst_n, out_valid && (step_pins != '0), step_pins[0], "follower step without lead")

endmodule

// ----- hw/rtl/mabsg_ctrl.sv -----
// ----------------------------------------------------------------------------
// mabsg_ctrl
// Sequencer: takes one input word, walks follower axes, hands off a result.
// ----------------------------------------------------------------------------
module mabsg_ctrl
    import mabsg_pkg::*;
#(
    parameter int AXES = AXES_DEFAULT,
    parameter int AW   = (AXES > 1) ? $clog2(AXES) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    func,
    output logic          out_valid,
    input  logic          out_ready,
    input  status_t       status,
    output cmd_t          cmd,
    output logic [AW-1:0] walk_axis,
    output logic [AW-1:0] rd_addr
);

    localparam int CW = (AW + 1 > 4) ? AW + 1 : 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] next_idx;
    logic          walk_more;
    logic          start_walk;

    // Index bookkeeping for the follower walk
    assign next_idx   = CW'(cnt_reg) + CW'(1);
    assign walk_more  = next_idx < CW'(status.axis_count);
    assign start_walk = (func == FUNC_STEP) && status.running && !status.lead_pin
                        && (status.axis_count > 4'd1);

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign walk_axis = cnt_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        rd_addr        = AW'(next_idx);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (start_walk)
                    begin
                        cmd.rd_en  = 1'b1;
                        rd_addr    = AW'(1);
                        cnt_next   = AW'(1);
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.walk_en = 1'b1;
                if (walk_more)
                begin
                    cmd.rd_en = 1'b1;
                    cnt_next  = AW'(next_idx);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hw/rtl/mabsg_datapath.sv -----
// ----------------------------------------------------------------------------
// mabsg_datapath
// Axis stores, Bresenham update unit, pin/direction state and result register.
// ----------------------------------------------------------------------------
module mabsg_datapath
    import mabsg_pkg::*;
#(
    parameter int AXES = AXES_DEFAULT,
    parameter int AW   = (AXES > 1) ? $clog2(AXES) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic [AW-1:0]       walk_axis,
    input  logic [AW-1:0]       rd_addr,
    output status_t             status,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [3:0]          cfg_data,
    input  logic [1:0]          func,
    input  logic [2:0]          axis,
    input  logic [30:0]         axis_rate,
    input  logic signed [31:0]  error_init,
    input  logic                direction,
    input  logic signed [31:0]  position_init,
    input  logic signed [31:0]  target_position,
    input  logic                reverse_request,
    output logic [PIN_W-1:0]    step_pins,
    output logic [PIN_W-1:0]    dir_pins,
    output logic signed [31:0]  lead_position,
    output logic                running,
    output logic                target_reached
);

    localparam int         LIMIT  = (AXES < 8) ? AXES : 8;
    localparam logic [4:0] AXES_W = 5'(AXES);

    // Axis stores (entry 0 of position and rate also kept in lead registers)
    logic [30:0] rate_mem [AXES];
    logic [31:0] err_mem  [AXES];
    logic [31:0] pos_mem  [AXES];

    logic [30:0] rate_rd_reg;
    logic [31:0] err_rd_reg;
    logic [31:0] pos_rd_reg;

    logic [30:0]      lead_rate_reg;
    logic [31:0]      lead_pos_reg;
    logic [31:0]      lead_target_reg;
    logic [PIN_W-1:0] pin_reg;
    logic [PIN_W-1:0] dir_reg;
    logic             run_reg;
    logic             last_reg;
    logic             reached_reg;
    logic             target_mode_reg;
    logic [3:0]       active_axes_reg;

    logic [3:0]       axis_count;
    logic [PIN_W-1:0] rev_mask;
    logic [31:0]      lead_next;
    logic             acc_load, acc_start, acc_step, acc_pulse;
    logic             load_ok, step_ok;
    logic [2:0]       wax;
    logic             fol_step;
    logic [31:0]      err_next;
    logic [31:0]      pos_next;

    // Clamp the configured axis count
    always_comb
    begin
        priority if (active_axes_reg == 4'd0)
            axis_count = 4'd1;
        else if (active_axes_reg > 4'(LIMIT))
            axis_count = 4'(LIMIT);
        else
            axis_count = active_axes_reg;
    end

    assign rev_mask = PIN_W'((9'd1 << axis_count) - 9'd1);

    // Word decode
    assign acc_load  = cmd.accept && (func == FUNC_LOAD);
    assign acc_start = cmd.accept && (func == FUNC_START);
    assign acc_step  = cmd.accept && (func == FUNC_STEP);
    assign acc_pulse = cmd.accept && (func == FUNC_PULSE);
    assign load_ok   = acc_load && ({2'b00, axis} < AXES_W);
    assign step_ok   = acc_step && run_reg && !pin_reg[0];

    // Lead axis step
    assign lead_next = dir_reg[0] ? lead_pos_reg + 32'd1 : lead_pos_reg - 32'd1;

    // Follower update from the registered store read
    assign wax      = 3'(walk_axis);
    assign fol_step = !err_rd_reg[31];
    assign err_next = err_rd_reg - (fol_step ? {1'b0, lead_rate_reg} : 32'd0)
                      + {1'b0, rate_rd_reg};
    assign pos_next = dir_reg[wax] ? pos_rd_reg + 32'd1 : pos_rd_reg - 32'd1;

    // Store writes and registered reads
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            rate_mem[AW'(axis)] <= axis_rate;
            err_mem[AW'(axis)]  <= error_init;
            pos_mem[AW'(axis)]  <= position_init;
        end
        else if (cmd.walk_en)
        begin
            err_mem[walk_axis] <= err_next;
            if (fol_step)
                pos_mem[walk_axis] <= pos_next;
        end
        if (cmd.rd_en)
        begin
            rate_rd_reg <= rate_mem[rd_addr];
            err_rd_reg  <= err_mem[rd_addr];
            pos_rd_reg  <= pos_mem[rd_addr];
        end
    end

    // Lead axis registers and result word
    always_ff @(posedge clk)
    begin
        if (load_ok && (axis == 3'd0))
        begin
            lead_rate_reg <= axis_rate;
            lead_pos_reg  <= position_init;
        end
        else if (step_ok)
        begin
            lead_pos_reg <= lead_next;
        end
        if (cmd.capture)
        begin
            step_pins      <= pin_reg;
            dir_pins       <= dir_reg;
            lead_position  <= lead_pos_reg;
            running        <= run_reg;
            target_reached <= reached_reg;
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_mode_reg <= 1'b1;
            active_axes_reg <= 4'd1;
            lead_target_reg <= '0;
            pin_reg         <= '0;
            dir_reg         <= '0;
            run_reg         <= 1'b0;
            last_reg        <= 1'b0;
            reached_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                priority if (cfg_index == REG_TARGET_MODE)
                    target_mode_reg <= cfg_data[0];
                else if (cfg_index == REG_ACTIVE_AXES)
                    active_axes_reg <= cfg_data;
            end
            if (load_ok)
            begin
                dir_reg[axis] <= direction;
                if (axis == 3'd0)
                    lead_target_reg <= target_position;
            end
            if (acc_start)
                run_reg <= 1'b1;
            if (step_ok)
            begin
                pin_reg[0] <= 1'b1;
                if (target_mode_reg && (lead_next == lead_target_reg))
                    last_reg <= 1'b1;
            end
            if (cmd.walk_en && fol_step)
                pin_reg[wax] <= 1'b1;
            if (acc_pulse && run_reg)
            begin
                pin_reg <= '0;
                if (reverse_request)
                    dir_reg <= dir_reg ^ rev_mask;
                if (last_reg)
                begin
                    last_reg <= 1'b0;
                    run_reg  <= 1'b0;
                end
            end
            if (cmd.accept)
                reached_reg <= acc_pulse && run_reg && last_reg && target_mode_reg;
        end
    end

    assign status.running    = run_reg;
    assign status.lead_pin   = pin_reg[0];
    assign status.axis_count = axis_count;

endmodule

// ----- tb/sv/multi_axis_bresenham_step_generator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_axis_bresenham_step_generator_top_tb
// Self-checking bench for the multi-axis Bresenham step generator. The bench
// predicts every result word and compares it with the block's output.
// A directed opening covers the extreme field values, every function and the
// corner cases of the move control. Most of the random part is complete
// moves: load, start, then step and pulse-end ticks, under several axis
// counts and both run modes. The rest is random noise words. Both channels
// stall at random, and the output side holds off long enough to back up
// the input.
// ----------------------------------------------------------------------------
import mabsg_pkg::*;

// One input word as seen on the input channel
typedef struct {
    func_t              fn;
    logic [2:0]         axis_idx;
    logic [30:0]        rate;
    logic signed [31:0] err;
    logic               dir;
    logic signed [31:0] pos;
    logic signed [31:0] tgt;
    logic               rev;
} axis_word_t;

// One result word
typedef struct {
    logic [7:0]         step_pins;
    logic [7:0]         dir_pins;
    logic signed [31:0] lead_pos;
    logic               running;
    logic               reached;
} pin_status_t;

// Step generator predictor and the queue of pin status words it owes
class step_scoreboard;
    logic [31:0] rate_q [8];
    logic [31:0] err_q [8];
    logic [31:0] pos_q [8];
    logic [7:0]  dir_q;
    logic [7:0]  pin_q;
    logic [31:0] lead_target;
    logic        run_q;
    logic        last_pulse;
    logic        target_mode;
    logic [3:0]  active_axes;
    pin_status_t status_due[$];
    int          mismatches;
    int          checked;

    function new();
        for (int i = 0; i < 8; i++)
        begin
            rate_q[i] = '0;
            err_q[i]  = '0;
            pos_q[i]  = '0;
        end
        dir_q       = '0;
        pin_q       = '0;
        lead_target = '0;
        run_q       = 1'b0;
        last_pulse  = 1'b0;
        target_mode = 1'b1;
        active_axes = 4'd1;
        mismatches  = 0;
        checked     = 0;
    endfunction

    function int pending();
        return status_due.size();
    endfunction

    function void write_reg(cfg_reg_t idx, logic [3:0] data);
        if (idx == REG_TARGET_MODE)
        begin
            target_mode = data[0];
        end
        else if (idx == REG_ACTIVE_AXES)
        begin
            active_axes = data;
        end
    endfunction

    // Zero counts as one axis; anything past the slot count saturates
    function int axis_span();
        int n;
        n = active_axes;
        if (n < 1)
        begin
            n = 1;
        end
        if (n > AXES_DEFAULT)
        begin
            n = AXES_DEFAULT;
        end
        return n;
    endfunction

    function void advance_axis(int a);
        pin_q[a] = 1'b1;
        if (dir_q[a])
        begin
            pos_q[a] = pos_q[a] + 32'd1;
        end
        else
        begin
            pos_q[a] = pos_q[a] - 32'd1;
        end
    endfunction

    // Apply one accepted input word and queue the status it should produce
    function void accept_word(axis_word_t w);
        pin_status_t s;
        int          n;
        n         = axis_span();
        s.reached = 1'b0;
        case (w.fn)
            FUNC_LOAD:
            begin
                rate_q[w.axis_idx] = {1'b0, w.rate};
                err_q[w.axis_idx]  = w.err;
                dir_q[w.axis_idx]  = w.dir;
                pos_q[w.axis_idx]  = w.pos;
                if (w.axis_idx == 3'd0)
                begin
                    lead_target = w.tgt;
                end
            end
            FUNC_START:
            begin
                run_q = 1'b1;
            end
            FUNC_STEP:
            begin
                // lead pin still high means the tick is dropped
                if (run_q && !pin_q[0])
                begin
                    advance_axis(0);
                    for (int a = 1; a < n; a++)
                    begin
                        if (!err_q[a][31])
                        begin
                            advance_axis(a);
                            err_q[a] = err_q[a] - rate_q[0];
                        end
                        err_q[a] = err_q[a] + rate_q[a];
                    end
                    if (target_mode && pos_q[0] == lead_target)
                    begin
                        last_pulse = 1'b1;
                    end
                end
            end
            FUNC_PULSE:
            begin
                if (run_q)
                begin
                    pin_q = '0;
                    if (w.rev)
                    begin
                        dir_q = dir_q ^ 8'((1 << n) - 1);
                    end
                    if (last_pulse)
                    begin
                        last_pulse = 1'b0;
                        run_q      = 1'b0;
                        s.reached  = target_mode;
                    end
                end
            end
        endcase
        s.step_pins = pin_q;
        s.dir_pins  = dir_q;
        s.lead_pos  = pos_q[0];
        s.running   = run_q;
        status_due.push_back(s);
    endfunction

    // Compare one result word with the oldest prediction
    function void check_status(pin_status_t got);
        pin_status_t want;
        checked++;
        if (status_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("ERROR: result word %0d arrived with nothing predicted", checked);
            end
            return;
        end
        want = status_due.pop_front();
        if (got.step_pins !== want.step_pins || got.dir_pins !== want.dir_pins ||
            got.lead_pos !== want.lead_pos || got.running !== want.running ||
            got.reached !== want.reached)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("ERROR: word %0d exp step=%h dir=%h pos=%0d run=%b reached=%b",
                         checked, want.step_pins, want.dir_pins, want.lead_pos,
                         want.running, want.reached);
                $display("       got step=%h dir=%h pos=%0d run=%b reached=%b",
                         got.step_pins, got.dir_pins, got.lead_pos, got.running,
                         got.reached);
            end
        end
    endfunction
endclass

module multi_axis_bresenham_step_generator_top_tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int WORD_GOAL   = 1700;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 12;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [3:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         func;
    logic [2:0]         axis;
    logic [30:0]        axis_rate;
    logic signed [31:0] error_init;
    logic               direction;
    logic signed [31:0] position_init;
    logic signed [31:0] target_position;
    logic               reverse_request;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         step_pins;
    logic [7:0]         dir_pins;
    logic signed [31:0] lead_position;
    logic               running;
    logic               target_reached;

    step_scoreboard sb;
    int cycle_count  = 0;
    int words_sent   = 0;
    int results_seen = 0;
    int burst_left   = 0;

    multi_axis_bresenham_step_generator_top dut (.*);

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Handshake monitor: register writes, accepted words, result words
    always @(posedge clk)
    begin
        axis_word_t  w;
        pin_status_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
            end
            if (in_valid && in_ready)
            begin
                w.fn       = func_t'(func);
                w.axis_idx = axis;
                w.rate     = axis_rate;
                w.err      = error_init;
                w.dir      = direction;
                w.pos      = position_init;
                w.tgt      = target_position;
                w.rev      = reverse_request;
                sb.accept_word(w);
            end
            if (out_valid && out_ready)
            begin
                got.step_pins = step_pins;
                got.dir_pins  = dir_pins;
                got.lead_pos  = lead_position;
                got.running   = running;
                got.reached   = target_reached;
                sb.check_status(got);
                results_seen++;
            end
        end
    end

    // Receiver: random stalls, plus two long hold-offs to back up the input
    initial
    begin : result_sink
        int r;
        int holds_done;
        holds_done = 0;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (holds_done < 2 && results_seen >= 500 + 700 * holds_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(1, 40)) @(posedge clk);
                end
                else
                begin
                    out_ready <= 1'b0;
                    if (r < 85)
                    begin
                        repeat ($urandom_range(1, 3)) @(posedge clk);
                    end
                    else if (r < 96)
                    begin
                        repeat ($urandom_range(4, 10)) @(posedge clk);
                    end
                    else
                    begin
                        repeat ($urandom_range(20, 40)) @(posedge clk);
                    end
                end
            end
        end
    end

    // Offer one word, hold it until taken, then maybe leave a gap
    task automatic push_word(input axis_word_t w);
        int r;
        int len;
        in_valid        <= 1'b1;
        func            <= w.fn;
        axis            <= w.axis_idx;
        axis_rate       <= w.rate;
        error_init      <= w.err;
        direction       <= w.dir;
        position_init   <= w.pos;
        target_position <= w.tgt;
        reverse_request <= w.rev;
        do @(posedge clk); while (!in_ready);
        words_sent++;
        // gap length; bursts run back to back
        r = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left--;
            len = 0;
        end
        else if (r < 4)
        begin
            burst_left = $urandom_range(20, 60);
            len = 0;
        end
        else if (r < 50)
        begin
            len = 0;
        end
        else if (r < 85)
        begin
            len = $urandom_range(1, 3);
        end
        else if (r < 96)
        begin
            len = $urandom_range(4, 10);
        end
        else
        begin
            len = $urandom_range(20, 40);
        end
        if (len > 0)
        begin
            in_valid <= 1'b0;
            repeat (len) @(posedge clk);
        end
    endtask

    // Wait until every predicted word is back and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [3:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(input logic tmode, input logic [3:0] n_axes);
        write_reg(REG_TARGET_MODE, {3'($urandom), tmode});
        write_reg(REG_ACTIVE_AXES, n_axes);
    endtask

    // Fully random word; other builders start from it so idle fields toggle
    function automatic axis_word_t noise_word();
        axis_word_t w;
        w.fn       = func_t'($urandom_range(0, 3));
        w.axis_idx = 3'($urandom);
        w.rate     = 31'($urandom);
        w.err      = $urandom;
        w.dir      = 1'($urandom);
        w.pos      = $urandom;
        w.tgt      = $urandom;
        w.rev      = 1'($urandom);
        return w;
    endfunction

    function automatic axis_word_t tick_word(input func_t f, input logic rev);
        axis_word_t w;
        w     = noise_word();
        w.fn  = f;
        w.rev = rev;
        return w;
    endfunction

    function automatic axis_word_t load_word(input logic [2:0] ax, input logic [30:0] rate,
                                             input logic [31:0] err, input logic dir,
                                             input logic [31:0] pos, input logic [31:0] tgt);
        axis_word_t w;
        w          = noise_word();
        w.fn       = FUNC_LOAD;
        w.axis_idx = ax;
        w.rate     = rate;
        w.err      = err;
        w.dir      = dir;
        w.pos      = pos;
        w.tgt      = tgt;
        return w;
    endfunction

    // Mostly near zero, some across the signed wrap, some anywhere
    function automatic logic [31:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 32'($urandom_range(0, 200)) - 32'd100;
        end
        else if (r < 78)
        begin
            return 32'h7FFF_FFF8 + 32'($urandom_range(0, 16));
        end
        else if (r < 85)
        begin
            return 32'hFFFF_FFF8 + 32'($urandom_range(0, 16));
        end
        return $urandom;
    endfunction

    // Usual Bresenham start: centered on zero, within half the lead rate
    function automatic logic [31:0] follower_error(input logic [30:0] lead_rate);
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom;
        end
        return 32'($urandom_range(0, lead_rate)) - 32'(lead_rate >> 1);
    endfunction

    // One well-formed move: lead target 1 to 12 steps out, then tick pairs
    task automatic run_move();
        logic [30:0] lead_rate;
        logic [31:0] start_pos;
        logic        lead_dir;
        int          span;
        if ($urandom_range(0, 9) == 0)
        begin
            lead_rate = 31'($urandom);
        end
        else
        begin
            lead_rate = 31'($urandom_range(1, 1000));
        end
        lead_dir  = 1'($urandom);
        span      = $urandom_range(1, 12);
        start_pos = pick_position();
        push_word(load_word(3'd0, lead_rate, follower_error(lead_rate), lead_dir, start_pos,
                            lead_dir ? start_pos + 32'(span) : start_pos - 32'(span)));
        for (int a = 1; a < 8; a++)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                push_word(load_word(3'(a), 31'($urandom_range(0, lead_rate)),
                                    follower_error(lead_rate), 1'($urandom),
                                    pick_position(), $urandom));
            end
        end
        push_word(tick_word(FUNC_START, 1'($urandom)));
        for (int i = 0; i < span + 2; i++)
        begin
            push_word(tick_word(FUNC_STEP, 1'($urandom)));
            if ($urandom_range(0, 9) == 0)
            begin
                push_word(tick_word(FUNC_STEP, 1'($urandom)));
            end
            if ($urandom_range(0, 19) == 0)
            begin
                push_word(noise_word());
            end
            push_word(tick_word(FUNC_PULSE, $urandom_range(0, 19) == 0));
        end
    endtask

    // Main sequence
    initial
    begin : stimulus
        int phase;
        int phase_end;
        sb              = new();
        rst_n           <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= REG_TARGET_MODE;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        func            <= FUNC_LOAD;
        axis            <= '0;
        axis_rate       <= '0;
        error_init      <= '0;
        direction       <= 1'b0;
        position_init   <= '0;
        target_position <= '0;
        reverse_request <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all eight axes loaded with extreme values, lead first
        set_mode(1'b1, 4'd8);
        push_word(load_word(3'd0, 31'h7FFF_FFFF, 32'h0000_0000, 1'b1,
                            32'h7FFF_FFFE, 32'h8000_0000));
        push_word(load_word(3'd1, 31'h0000_0000, 32'h8000_0000, 1'b0,
                            32'h8000_0000, 32'hFFFF_FFFF));
        push_word(load_word(3'd2, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                            32'h7FFF_FFFF, 32'h0000_0000));
        push_word(load_word(3'd3, 31'h0000_0001, 32'h0000_0000, 1'b1,
                            32'hFFFF_FFFF, 32'h7FFF_FFFF));
        push_word(load_word(3'd4, 31'h4000_0000, 32'hFFFF_FFFF, 1'b0,
                            32'h0000_0000, 32'h8000_0000));
        push_word(load_word(3'd5, 31'h0000_3039, 32'hAAAA_AAAA, 1'b1,
                            32'h5555_5555, 32'hAAAA_AAAA));
        push_word(load_word(3'd6, 31'h2AAA_AAAA, 32'h5555_5555, 1'b0,
                            32'hAAAA_AAAA, 32'h5555_5555));
        push_word(load_word(3'd7, 31'h5555_5555, 32'h0000_0001, 1'b1,
                            32'h0000_0001, 32'h0000_0000));
        // ticks while stopped are dropped
        push_word(tick_word(FUNC_STEP, 1'b0));
        push_word(tick_word(FUNC_PULSE, 1'b1));
        push_word(tick_word(FUNC_START, 1'b0));
        push_word(tick_word(FUNC_STEP, 1'b0));
        // second step while the lead pin is still high
        push_word(tick_word(FUNC_STEP, 1'b1));
        push_word(tick_word(FUNC_PULSE, 1'b0));
        // start while running, then the step that lands on target
        push_word(tick_word(FUNC_START, 1'b1));
        push_word(tick_word(FUNC_STEP, 1'b0));
        push_word(load_word(3'd3, 31'h0000_0007, 32'hFFFF_FFF0, 1'b0,
                            32'h0000_0010, 32'h1234_5678));
        push_word(tick_word(FUNC_PULSE, 1'b1));
        push_word(tick_word(FUNC_STEP, 1'b0));
        // last pulse pending when the mode drops to free running
        push_word(load_word(3'd0, 31'h0000_0005, 32'h0000_0000, 1'b1,
                            32'h0000_000A, 32'h0000_000B));
        push_word(tick_word(FUNC_START, 1'b0));
        push_word(tick_word(FUNC_STEP, 1'b0));
        write_reg(REG_TARGET_MODE, 4'b1110);
        push_word(tick_word(FUNC_PULSE, 1'b0));
        push_word(tick_word(FUNC_START, 1'b0));
        push_word(tick_word(FUNC_STEP, 1'b1));
        push_word(tick_word(FUNC_PULSE, 1'b1));

        // Random phases under changing mode and axis count
        phase = 0;
        while (words_sent < WORD_GOAL)
        begin
            case (phase)
                0: set_mode(1'b1, 4'd0);
                1: set_mode(1'b0, 4'd15);
                2: set_mode(1'b1, 4'd8);
                3: set_mode(1'b0, 4'd1);
                default: set_mode(1'($urandom), 4'($urandom_range(0, 15)));
            endcase
            phase_end = words_sent + 200;
            if (phase_end > WORD_GOAL)
            begin
                phase_end = WORD_GOAL;
            end
            while (words_sent < phase_end)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    run_move();
                end
                else
                begin
                    push_word(noise_word());
                end
            end
            phase++;
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
